### rtl/core/ufc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared constants and controller/datapath signal groups for the
// union-find connectivity engine.
// ----------------------------------------------------------------------------
package ufc_pkg;

	localparam int ELEMENTS = 1024;
	localparam int IDX_W    = $clog2(ELEMENTS);
	localparam int FIELD_W  = 10;

	localparam logic KIND_UNION = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;       // write one reset entry and advance the clear counter
		logic take;         // latch the input item and start the first find
		logic rd_cur;       // read the parent of the current element
		logic rd_next;      // follow the read data: current <= parent, read it
		logic root_found;   // capture the root and restart at the walk origin
		logic cmp_wr;       // point the current entry at the root
		logic start_second; // keep the first root and start the second find
		logic unite;        // point the first root at the second root
		logic emit;         // load the output register with the comparison
	} ufc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic cur_is_root;
		logic rd_is_top;
		logic cur_is_top;
		logic kind_query;
		logic out_free;
	} ufc_sts_t;

	function automatic idx_t elem_index(input logic [FIELD_W-1:0] v);
		return IDX_W'(v % ELEMENTS);
	endfunction

endpackage
`default_nettype wire

### rtl/core/ufc_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_item_if
// Input channel: one union or connectivity query item per transfer.
// ----------------------------------------------------------------------------
interface ufc_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [9:0] first_element;
	logic [9:0] second_element;

	modport source (output valid, kind, first_element, second_element, input ready);
	modport sink   (input valid, kind, first_element, second_element, output ready);
endinterface
`default_nettype wire

### rtl/core/ufc_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_result_if
// Output channel: one connectivity answer per transfer.
// ----------------------------------------------------------------------------
interface ufc_result_if;
	logic valid;
	logic ready;
	logic connected;

	modport source (output valid, connected, input ready);
	modport sink   (input valid, connected, output ready);
endinterface
`default_nettype wire

### rtl/core/ufc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_datapath
// Parent table memory, walk registers, clear counter and output register.
// ----------------------------------------------------------------------------
module ufc_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ufc_pkg::ufc_cmd_t cmd,
	output ufc_pkg::ufc_sts_t     sts,
	input  wire logic             kind,
	input  wire logic [9:0]       first_element,
	input  wire logic [9:0]       second_element,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  connected
);
	import ufc_pkg::*;

	idx_t parent_mem [ELEMENTS];

	idx_t clr_q;
	idx_t b_q;
	logic kind_q;
	idx_t cur_q, start_q, top_q, ra_q;
	idx_t rd_data_q;
	logic out_valid_q, connected_q;

	logic wr_en;
	idx_t wr_addr, wr_data;
	logic rd_en;
	idx_t rd_addr;

	always_comb begin
		wr_en   = cmd.clr_wr | cmd.cmp_wr | cmd.unite;
		wr_addr = clr_q;
		wr_data = clr_q;
		if (cmd.cmp_wr) begin
			wr_addr = cur_q;
			wr_data = top_q;
		end else if (cmd.unite) begin
			wr_addr = ra_q;
			wr_data = top_q;
		end
		rd_en   = cmd.rd_cur | cmd.rd_next;
		rd_addr = cmd.rd_next ? rd_data_q : cur_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			parent_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= parent_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			b_q     <= elem_index(second_element);
			kind_q  <= kind;
			cur_q   <= elem_index(first_element);
			start_q <= elem_index(first_element);
		end else if (cmd.rd_next) begin
			cur_q <= rd_data_q;
		end else if (cmd.root_found) begin
			top_q <= cur_q;
			cur_q <= start_q;
		end else if (cmd.start_second) begin
			ra_q    <= top_q;
			cur_q   <= b_q;
			start_q <= b_q;
		end
	end

	// The output register frees the controller as soon as a result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			connected_q <= (ra_q == top_q);
		end
	end

	assign out_valid = out_valid_q;
	assign connected = connected_q;

	always_comb begin
		sts.clr_last    = (clr_q == IDX_W'(ELEMENTS - 1));
		sts.cur_is_root = (rd_data_q == cur_q);
		sts.rd_is_top   = (rd_data_q == top_q);
		sts.cur_is_top  = (cur_q == top_q);
		sts.kind_query  = (kind_q == KIND_QUERY);
		sts.out_free    = !out_valid_q || out_ready;
	end

	// Compression never rewrites the root itself.
	a_cmp_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_wr |-> cur_q != top_q)
		else $error("compression write targets the root");

	// Only a union item links two roots.
	a_unite_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unite |-> kind_q == KIND_UNION)
		else $error("root link issued for a query item");

endmodule
`default_nettype wire

### rtl/core/ufc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufc_ctrl
// Controller for the clearing pass and the two finds with path compression.
// ----------------------------------------------------------------------------
module ufc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ufc_pkg::ufc_sts_t sts,
	output ufc_pkg::ufc_cmd_t     cmd
);
	import ufc_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_FIND_RD  = 7'b0000100,
		S_FIND_CHK = 7'b0001000,
		S_CMP_RD   = 7'b0010000,
		S_CMP_WR   = 7'b0100000,
		S_FIN      = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   second_q, second_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		second_d = second_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					second_d = 1'b0;
					state_d  = S_FIND_RD;
				end
			end
			S_FIND_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_FIND_CHK;
			end
			S_FIND_CHK: begin
				if (sts.cur_is_root) begin
					cmd.root_found = 1'b1;
					state_d        = S_CMP_RD;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			S_CMP_RD: begin
				if (sts.cur_is_top) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_CMP_WR;
				end
			end
			S_CMP_WR: begin
				// Rewrite this entry and move on to its old parent in the same cycle.
				cmd.cmp_wr  = 1'b1;
				cmd.rd_next = 1'b1;
				if (sts.rd_is_top) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!second_q) begin
					cmd.start_second = 1'b1;
					second_d         = 1'b1;
					state_d          = S_FIND_RD;
				end else if (!sts.kind_query) begin
					cmd.unite = 1'b1;
					state_d   = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	// The clearing pass ends only after the last entry was written.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && state_d != S_CLEAR) |-> sts.clr_last)
		else $error("clearing pass left early");

	// A result is loaded only for a query, into a free output register.
	a_emit_query: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (sts.kind_query && sts.out_free && second_q))
		else $error("result emitted outside a finished query");

	// Finishing an item always returns to idle.
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.unite) |=> state_q == S_IDLE)
		else $error("controller did not return to idle");

endmodule
`default_nettype wire

### rtl/core/union_find_connectivity_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_connectivity_top
// Disjoint-set engine with path compression over a single-port-pair table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ELEMENTS (1024) entries
// that sets every parent entry to its own index; item.ready stays low meanwhile.
// Each item then runs two finds, one after the other, on a parent table with
// one read and one write port. A find reads entries up to the root, one step
// per parent, then walks the path again from its origin and rewrites each
// entry on it to point at the root (path compression). After both finds a
// union links the first root to the second; a query loads the comparison.
// One item is processed at a time. A query result sits in an output register,
// so the next item is taken while it waits; a second query result waits for
// that register to drain.
// ----------------------------------------------------------------------------
module union_find_connectivity_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ufc_item_if.sink    item,
	ufc_result_if.source result
);
	import ufc_pkg::*;

	ufc_cmd_t cmd;
	ufc_sts_t sts;

	ufc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ufc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (item.kind),
		.first_element  (item.first_element),
		.second_element (item.second_element),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.connected      (result.connected)
	);

endmodule
`default_nettype wire
